FILE: rtl/qdc_ewp_pkg.sv
// shared types, field positions and constants of the qdc event word parser
package qdc_ewp_pkg;

   localparam int QDC_CHANNELS    = 16;
   localparam int QDC_CHARGE_BITS = 12;
   localparam int QDC_QUEUE_DEPTH = 4;

   localparam int WORD_W    = 32;
   localparam int CHANNEL_W = 4;
   localparam int CHARGE_W  = 13;
   localparam int COUNT_W   = 6;

   // bit positions inside a readout word
   localparam int TYPE_LSB    = 25;
   localparam int COUNT_LSB   = 8;
   localparam int RANGE_BIT   = 16;
   localparam int CHANNEL_LSB = 17;

   localparam logic [CHARGE_W-1:0] NOT_FOUND_RESET = '1;

   typedef enum logic [1:0] {
      WT_DATA   = 2'd0,
      WT_HEADER = 2'd1,
      WT_END    = 2'd2,
      WT_FILLER = 2'd3
   } word_type_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_DUMP,
      CMD_ERROR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type            op;
      logic                  gain_range;
      logic [CHANNEL_W-1:0]  channel;
      logic [CHARGE_W-1:0]   charge;
   } cmd_type;

endpackage

FILE: rtl/qdc_ewp_if.sv
// valid/ready channel interfaces for readout words and results
interface qdc_ewp_req_if;
   import qdc_ewp_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface qdc_ewp_rsp_if;
   import qdc_ewp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic                        gain_range;
   logic [CHANNEL_W-1:0]        channel;
   logic signed [CHARGE_W-1:0]  charge;
   logic                        last;

   modport source (output valid, output kind, output gain_range, output channel,
                   output charge, output last, input ready);
   modport sink   (input valid, input kind, input gain_range, input channel,
                   input charge, input last, output ready);
endinterface

FILE: rtl/qdc_ewp_queue.sv
// small command queue between the word parser and the table engine
module qdc_ewp_queue #(
   parameter int DEPTH = qdc_ewp_pkg::QDC_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qdc_ewp_pkg::cmd_type  push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output qdc_ewp_pkg::cmd_type  head_cmd
);
   import qdc_ewp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/qdc_ewp_front.sv
// word parser: checks word order per event and turns words into table commands
module qdc_ewp_front #(
   parameter int CHANNELS    = qdc_ewp_pkg::QDC_CHANNELS,
   parameter int CHARGE_BITS = qdc_ewp_pkg::QDC_CHARGE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   qdc_ewp_req_if.sink           req_ch,
   output logic                  push,
   output qdc_ewp_pkg::cmd_type  push_cmd,
   input  logic                  queue_full
);
   import qdc_ewp_pkg::*;

   localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_END
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_W-1:0]    expected_ff, expected_in;
   logic [COUNT_W-1:0]    seen_ff, seen_in;
   logic [COUNT_W-1:0]    seen_next;
   logic [COUNT_W-1:0]    word_count;
   logic                  resync_ff, resync_in;
   logic                  accept;
   logic                  error;
   word_type_type         wtype;
   logic [CHANNEL_W-1:0]  word_ch;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign wtype        = word_type_type'(req_ch.word[TYPE_LSB +: 2]);
   assign word_ch      = req_ch.word[CHANNEL_LSB +: CHANNEL_W];
   assign word_count   = req_ch.word[COUNT_LSB +: COUNT_W];
   assign seen_next    = seen_ff + 1'b1;

   always_comb begin
      phase_in            = phase_ff;
      expected_in         = expected_ff;
      seen_in             = seen_ff;
      resync_in           = resync_ff;
      error               = 1'b0;
      push                = 1'b0;
      push_cmd.op         = CMD_WRITE;
      push_cmd.gain_range = req_ch.word[RANGE_BIT];
      push_cmd.channel    = word_ch;
      push_cmd.charge     = CHARGE_W'(req_ch.word[CHARGE_BITS-1:0]);

      // filler is always skipped, and so is anything but a header while resyncing
      if (accept && (wtype != WT_FILLER) && !(resync_ff && (wtype != WT_HEADER))) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (wtype != WT_HEADER) begin
                  error = 1'b1;
               end else begin
                  resync_in   = 1'b0;
                  expected_in = word_count;
                  seen_in     = '0;
                  phase_in    = (word_count != '0) ? PH_DATA : PH_END;
               end
            end
            PH_DATA: begin
               if (wtype != WT_DATA) begin
                  error = 1'b1;
               end else begin
                  push    = ({1'b0, word_ch} < CH_LIMIT);
                  seen_in = seen_next;
                  if (seen_next == expected_ff) begin
                     phase_in = PH_END;
                  end
               end
            end
            default: begin
               if (wtype != WT_END) begin
                  error = 1'b1;
               end else begin
                  push        = 1'b1;
                  push_cmd.op = CMD_DUMP;
                  phase_in    = PH_HEADER;
               end
            end
         endcase
         if (error) begin
            push        = 1'b1;
            push_cmd.op = CMD_ERROR;
            phase_in    = PH_HEADER;
            resync_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         expected_ff <= '0;
         seen_ff     <= '0;
         resync_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         resync_ff   <= resync_in;
      end
   end

endmodule

FILE: rtl/qdc_ewp_back.sv
// table engine: writes charges, dumps the table at end of block, emits errors
module qdc_ewp_back #(
   parameter int CHANNELS = qdc_ewp_pkg::QDC_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  qdc_ewp_pkg::cmd_type                head_cmd,
   output logic                                pop,
   input  logic [qdc_ewp_pkg::CHARGE_W-1:0]    not_found,
   qdc_ewp_rsp_if.source                       rsp_ch
);
   import qdc_ewp_pkg::*;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNELS - 1);

   typedef enum logic {
      ST_RUN,
      ST_DUMP
   } state_type;

   state_type             state_ff, state_in;
   logic                  dump_range_ff, dump_range_in;
   logic [CH_IDX_W-1:0]   dump_ch_ff, dump_ch_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_range_ff, rsp_range_in;
   logic [CHANNEL_W-1:0]  rsp_channel_ff, rsp_channel_in;
   logic [CHARGE_W-1:0]   rsp_charge_ff, rsp_charge_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CHARGE_W-1:0]   charge_ff [2][CHANNELS];
   logic                  valid_ff [2][CHANNELS];
   logic [CHARGE_W-1:0]   clear_value_ff;
   logic                  tbl_we;
   logic                  tbl_clear;
   logic                  out_free;
   logic [CHARGE_W-1:0]   dump_entry;
   logic [CH_IDX_W-1:0]   write_ch;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign write_ch   = head_cmd.channel[CH_IDX_W-1:0];
   // entries untouched since the last clear read as the value used at that clear
   assign dump_entry = valid_ff[dump_range_ff][dump_ch_ff] ?
                       charge_ff[dump_range_ff][dump_ch_ff] : clear_value_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.gain_range = rsp_range_ff;
   assign rsp_ch.channel    = rsp_channel_ff;
   assign rsp_ch.charge     = rsp_charge_ff;
   assign rsp_ch.last       = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      dump_range_in  = dump_range_ff;
      dump_ch_in     = dump_ch_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_range_in   = rsp_range_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_charge_in  = rsp_charge_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;
      tbl_we         = 1'b0;
      tbl_clear      = 1'b0;

      unique case (state_ff)
         ST_RUN: begin
            if (head_valid) begin
               unique case (head_cmd.op)
                  CMD_WRITE: begin
                     pop    = 1'b1;
                     tbl_we = 1'b1;
                  end
                  CMD_DUMP: begin
                     pop           = 1'b1;
                     state_in      = ST_DUMP;
                     dump_range_in = 1'b0;
                     dump_ch_in    = '0;
                  end
                  CMD_ERROR: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = 1'b1;
                        rsp_range_in   = 1'b0;
                        rsp_channel_in = '0;
                        rsp_charge_in  = '0;
                        rsp_last_in    = 1'b1;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = 1'b0;
               rsp_range_in   = dump_range_ff;
               rsp_channel_in = CHANNEL_W'(dump_ch_ff);
               rsp_charge_in  = dump_entry;
               rsp_last_in    = dump_range_ff && (dump_ch_ff == CH_LAST);
               if (dump_ch_ff == CH_LAST) begin
                  dump_ch_in = '0;
                  if (dump_range_ff) begin
                     state_in  = ST_RUN;
                     tbl_clear = 1'b1;
                  end else begin
                     dump_range_in = 1'b1;
                  end
               end else begin
                  dump_ch_in = dump_ch_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         dump_range_ff <= 1'b0;
         dump_ch_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dump_range_ff <= dump_range_in;
         dump_ch_ff    <= dump_ch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_range_ff   <= rsp_range_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_charge_ff  <= rsp_charge_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '{default: 1'b0};
         clear_value_ff <= NOT_FOUND_RESET;
      end else if (tbl_clear) begin
         valid_ff       <= '{default: 1'b0};
         clear_value_ff <= not_found;
      end else if (tbl_we) begin
         valid_ff[head_cmd.gain_range][write_ch] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         charge_ff[head_cmd.gain_range][write_ch] <= head_cmd.charge;
      end
   end

endmodule

FILE: rtl/qdc_event_word_parser_unit.sv
// latency: an error result goes through the queue and the result register; the first
//   table entry of a dump through the queue, the dump state and the result register
// throughput: one word per cycle while the command queue has room; the back end
//   takes no command during a dump (one output register, one entry a cycle if ready)
// reset: synchronous, active high; parser back to expect header, queue empty,
//   table reads as not-found (-1), no clearing pass needed
module qdc_event_word_parser_unit #(
   parameter int CHANNELS    = qdc_ewp_pkg::QDC_CHANNELS,
   parameter int CHARGE_BITS = qdc_ewp_pkg::QDC_CHARGE_BITS,
   parameter int QUEUE_DEPTH = qdc_ewp_pkg::QDC_QUEUE_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   qdc_ewp_req_if.sink                              req_ch,
   qdc_ewp_rsp_if.source                            rsp_ch,
   input  logic                                     csr_we,
   input  logic signed [qdc_ewp_pkg::CHARGE_W-1:0]  csr_wdata
);
   import qdc_ewp_pkg::*;

   // front to queue
   logic                 push;
   cmd_type              push_cmd;
   logic                 queue_full;

   // queue to back
   logic                 head_valid;
   cmd_type              head_cmd;
   logic                 pop;

   // not-found charge, applied at the next table clear only
   logic [CHARGE_W-1:0]  not_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         not_found_ff <= NOT_FOUND_RESET;
      end else if (csr_we) begin
         not_found_ff <= csr_wdata;
      end
   end

   // parser: tracks header / data / end order and the channel count,
   // resyncs on the next header after a misplaced word
   qdc_ewp_front #(
      .CHANNELS    (CHANNELS),
      .CHARGE_BITS (CHARGE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // decouples word intake from the dump, so words keep flowing until it fills
   qdc_ewp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // charge table, dump sequencer and the registered result stage
   qdc_ewp_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .not_found  (not_found_ff),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: rtl/qdc_ewp_checker.sv
// port-level checks on the result channel, bound to the parser unit
module qdc_ewp_checker #(
   parameter int CHANNELS = qdc_ewp_pkg::QDC_CHANNELS
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic                                     rsp_kind,
   input logic                                     rsp_gain_range,
   input logic [qdc_ewp_pkg::CHANNEL_W-1:0]        rsp_channel,
   input logic signed [qdc_ewp_pkg::CHARGE_W-1:0]  rsp_charge,
   input logic                                     rsp_last
);
   import qdc_ewp_pkg::*;

   localparam logic [CHANNEL_W-1:0] CH_LAST = CHANNEL_W'(CHANNELS - 1);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an error item is a single last item with all payload zero
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |->
         rsp_last && !rsp_gain_range && (rsp_channel == '0) && (rsp_charge == '0))
      else $error("malformed error item");

   // last marks exactly the final entry of a dump
   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |->
         (rsp_last == (rsp_gain_range && (rsp_channel == CH_LAST))))
      else $error("last flag not on the final table entry");

   // a stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_kind) && $stable(rsp_gain_range) &&
         $stable(rsp_channel) && $stable(rsp_charge) && $stable(rsp_last))
      else $error("result changed while stalled");

endmodule

bind qdc_event_word_parser_unit qdc_ewp_checker #(
   .CHANNELS (CHANNELS)
) u_qdc_ewp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_gain_range (rsp_ch.gain_range),
   .rsp_channel    (rsp_ch.channel),
   .rsp_charge     (rsp_ch.charge),
   .rsp_last       (rsp_ch.last)
);
